@@ sv/scc_pkg.sv @@
// Shared constants for the second-chance cache set: op codes, status codes,
// register index and the minimum capacity. No dependencies.
package scc_pkg;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_MISS = 1'b1;

	// register index (byte address / 4)
	localparam logic REG_WAYS = 1'b0;

	localparam logic [3:0] WAYS_RESET = 4'd8;
	localparam int         MIN_WAYS   = 2;

endpackage

@@ sv/second_chance_cache_set.sv @@
// Second-chance replacement cache set, top level: sequencer, order list,
// key/value memories and APB register. Uses scc_pkg and scc_mover.
//
// Usage: pulse start with op/key/value_in while busy is low; the word is taken
// at that edge and busy rises. When the operation ends, done is high for one
// cycle with status and value_out; the receiver cannot stall this, and a new
// start may be issued in the same cycle that done is shown.
// Ops: get returns the value on a hit and sets the reference bit; put writes
// or inserts (evicting by second chance when the set is full); delete removes
// an entry and closes the gap.
// Lookup walks the live entries oldest first through one registered memory
// read port and one key comparator, one entry per cycle, and stops at the
// first hit or after the last live entry. A put that needs a new slot then
// goes through an append step and, when the set is full, first through an
// eviction step that rotates referenced entries to the tail until the oldest
// entry has a clear bit and is evicted.
// Capacity is the ways_in_use register at byte address 0 (APB, pready tied
// high), clamped to 2..WAYS; write it only while idle.
// Reset clears the entry count and reference bits, loads the order list with
// slot indices in order and sets ways_in_use to 8; no clearing pass is needed.
module second_chance_cache_set import scc_pkg::*; #(
	parameter int WAYS       = 8,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value_in,
	output logic                  done,
	output logic                  status,
	output logic [VALUE_BITS-1:0] value_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int IW = $clog2(WAYS);
	localparam int CW = $clog2(WAYS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOK   = 3'd1;
	localparam logic [2:0] S_ACT    = 3'd2;
	localparam logic [2:0] S_EVICT  = 3'd3;
	localparam logic [2:0] S_APPEND = 3'd4;

	logic [2:0]              state_q;
	logic [3:0]              ways_q;
	logic [1:0]              op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           rd_idx_q;
	logic [WAYS-1:0][IW-1:0] order_q;
	logic [WAYS-1:0]         ref_q;

	logic                    vld_s1;
	logic [IW-1:0]           pos_s1;
	logic [IW-1:0]           phys_s1;

	logic [KEY_BITS-1:0]     key_mem [WAYS];
	logic [VALUE_BITS-1:0]   val_mem [WAYS];
	logic [KEY_BITS-1:0]     key_rd_q;
	logic [VALUE_BITS-1:0]   val_rd_q;

	logic                    hit_q;
	logic [IW-1:0]           hit_pos_q;
	logic [IW-1:0]           hit_phys_q;
	logic [VALUE_BITS-1:0]   hit_val_q;

	logic                    done_q;
	logic                    status_q;
	logic [VALUE_BITS-1:0]   value_out_q;

	// ---- register port ----
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WAYS) ? {28'b0, ways_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= WAYS_RESET;
		end else if (cfg_wr && paddr[2] == REG_WAYS) begin
			ways_q <= pwdata[3:0];
		end
	end

	// ---- capacity and control decode ----
	logic [7:0]    cfg8, lim8, cap8;
	logic          full;
	logic [IW-1:0] ord_addr;
	logic [IW-1:0] ord_rd;
	logic          issue;
	logic          match;
	logic          look_miss;
	logic [CW-1:0] cnt_m1;

	assign cfg8 = {4'b0, ways_q};
	assign lim8 = 8'(WAYS);
	assign cap8 = (cfg8 < 8'(MIN_WAYS)) ? 8'(MIN_WAYS) : ((cfg8 > lim8) ? lim8 : cfg8);
	assign full = 8'(count_q) >= cap8;

	assign ord_addr  = (state_q == S_APPEND) ? count_q[IW-1:0] : rd_idx_q[IW-1:0];
	assign ord_rd    = order_q[ord_addr];
	assign issue     = (state_q == S_LOOK) && (rd_idx_q < count_q);
	assign match     = vld_s1 && (key_rd_q == key_q);
	assign look_miss = (state_q == S_LOOK) && !vld_s1 && !issue;
	assign cnt_m1    = count_q - CW'(1);

	// ---- move unit: delete, rotate and evict all go through it ----
	logic [IW-1:0]           mv_head, mv_tail, mv_phys;
	logic [WAYS-1:0][IW-1:0] ord_nxt;
	logic [WAYS-1:0]         ref_nxt;
	logic                    rotate;
	logic                    mv_en;
	logic                    del_hit;

	assign del_hit = (state_q == S_ACT) && (op_q == OP_DEL) && hit_q;
	assign rotate  = (state_q == S_EVICT) && ref_q[0];
	assign mv_en   = del_hit || (state_q == S_EVICT);
	assign mv_head = (state_q == S_ACT) ? hit_pos_q : IW'(0);
	assign mv_tail = rotate ? cnt_m1[IW-1:0] : IW'(WAYS - 1);
	assign mv_phys = (state_q == S_ACT) ? hit_phys_q : order_q[0];

	scc_mover #(
		.WAYS(WAYS),
		.IW  (IW)
	) u_mover (
		.ord_cur(order_q),
		.ref_cur(ref_q),
		.head   (mv_head),
		.tail   (mv_tail),
		.mv_phys(mv_phys),
		.ord_nxt(ord_nxt),
		.ref_nxt(ref_nxt)
	);

	// ---- key/value memories, one write and one registered read port ----
	logic          mem_we;
	logic [IW-1:0] mem_waddr;

	assign mem_we    = ((state_q == S_ACT) && (op_q == OP_PUT) && hit_q) ||
	                   (state_q == S_APPEND);
	assign mem_waddr = (state_q == S_APPEND) ? ord_rd : hit_phys_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= key_q;
			val_mem[mem_waddr] <= val_q;
		end
		key_rd_q <= key_mem[ord_rd];
		val_rd_q <= val_mem[ord_rd];
	end

	// ---- input word and lookup pipeline payload ----
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value_in;
		end
		pos_s1  <= rd_idx_q[IW-1:0];
		phys_s1 <= ord_rd;
		if (match) begin
			hit_pos_q  <= pos_s1;
			hit_phys_q <= phys_s1;
			hit_val_q  <= val_rd_q;
		end
	end

	// ---- sequencer ----
	logic finish;
	assign finish = ((state_q == S_ACT) && !((op_q == OP_PUT) && !hit_q)) ||
	                (state_q == S_APPEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			ref_q    <= '0;
			for (int j = 0; j < WAYS; j++) begin
				order_q[j] <= IW'(j);
			end
		end else begin
			vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_LOOK;
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
					end
				end
				S_LOOK: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_ACT;
					end else if (look_miss) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (hit_q && (op_q == OP_GET || op_q == OP_PUT)) begin
						ref_q[hit_pos_q] <= 1'b1;
					end
					if (del_hit) begin
						order_q <= ord_nxt;
						ref_q   <= ref_nxt;
						count_q <= cnt_m1;
					end
					if (op_q == OP_PUT && !hit_q) begin
						state_q <= full ? S_EVICT : S_APPEND;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EVICT: begin
					order_q <= ord_nxt;
					ref_q   <= ref_nxt;
					// oldest with a clear bit goes; otherwise it rotates to the tail
					if (!rotate) begin
						count_q <= cnt_m1;
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					ref_q[count_q[IW-1:0]] <= 1'b1;
					count_q                <= count_q + CW'(1);
					state_q                <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---- result word ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (op_q == OP_PUT) begin
				status_q <= ST_OK;
			end else if (op_q == OP_GET || op_q == OP_DEL) begin
				status_q <= hit_q ? ST_OK : ST_MISS;
			end else begin
				status_q <= ST_MISS;
			end
			value_out_q <= (op_q == OP_GET && hit_q) ? hit_val_q : '0;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WAYS))
		else $error("entry count above WAYS");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without an operation in flight");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		del_hit |=> (count_q == $past(cnt_m1)))
		else $error("delete hit did not shrink the set");

	a_evict_progress: assert property (@(posedge clk) disable iff (!arst_n)
		rotate |=> !ref_q[$past(cnt_m1[IW-1:0])])
		else $error("rotated entry kept its reference bit");
`endif

endmodule

@@ sv/scc_mover.sv @@
// Order-list move unit: takes the entry at position head out, closes the gap
// and drops the given slot index at position tail (tail >= head). Uses scc_pkg.
module scc_mover import scc_pkg::*; #(
	parameter int WAYS = 8,
	parameter int IW   = 3
) (
	input  logic [WAYS-1:0][IW-1:0] ord_cur,
	input  logic [WAYS-1:0]         ref_cur,
	input  logic [IW-1:0]           head,
	input  logic [IW-1:0]           tail,
	input  logic [IW-1:0]           mv_phys,
	output logic [WAYS-1:0][IW-1:0] ord_nxt,
	output logic [WAYS-1:0]         ref_nxt
);

	logic [WAYS-1:0][IW-1:0] ord_sh;
	logic [WAYS-1:0]         ref_sh;

	assign ord_sh = {IW'(0), ord_cur[WAYS-1:1]};
	assign ref_sh = {1'b0, ref_cur[WAYS-1:1]};

	always_comb begin
		for (int j = 0; j < WAYS; j++) begin
			if (IW'(j) == tail) begin
				ord_nxt[j] = mv_phys;
				ref_nxt[j] = 1'b0;   // moved entry loses its second chance
			end else if (IW'(j) >= head && IW'(j) < tail) begin
				ord_nxt[j] = ord_sh[j];
				ref_nxt[j] = ref_sh[j];
			end else begin
				ord_nxt[j] = ord_cur[j];
				ref_nxt[j] = ref_cur[j];
			end
		end
	end

endmodule
